@@ rtl/ffha_pkg.sv @@
// Shared constants, codes and types for the first-fit heap allocator.
package ffha_pkg;
	localparam int MAX_BLOCKS = 64;
	localparam int IDX_W = $clog2(MAX_BLOCKS);
	localparam int CNT_W = IDX_W + 1;
	localparam int ARENA_BYTES = 1048576;
	localparam int PAGE_BYTES = 4096;
	localparam int PAGE_SH = $clog2(PAGE_BYTES);
	localparam int HEADER_BYTES = 32;
	localparam int MIN_SPLIT_BYTES = 32;
	localparam int ADDR_W = 20;
	localparam int SIZE_W = 21;
	localparam int CALC_W = 24;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOBLK = 2'd1;
	localparam logic [1:0] ST_UNKNOWN = 2'd2;

	localparam logic MODE_ALLOC = 1'b0;

	typedef struct packed {
		logic [ADDR_W-1:0] off;
		logic [ADDR_W-1:0] bytes;
		logic fr;
	} entry_t;

	// Memory command from sequencer to table.
	typedef struct packed {
		logic we;
		logic [IDX_W-1:0] waddr;
		entry_t wdata;
		logic [IDX_W-1:0] raddr;
	} tbl_cmd_t;
endpackage

@@ rtl/ffha_table.sv @@
// Block table memory: one write port, one registered read port.
module ffha_table (
	input logic clk,
	input ffha_pkg::tbl_cmd_t cmd,
	output ffha_pkg::entry_t rdata
);
	ffha_pkg::entry_t mem [ffha_pkg::MAX_BLOCKS];

	always_ff @(posedge clk) begin
		if (cmd.we) begin
			mem[cmd.waddr] <= cmd.wdata;
		end
		rdata <= mem[cmd.raddr];
	end
endmodule

@@ rtl/first_fit_heap_allocator_top.sv @@
// Top level: sequencer over the block table with one shared adder/compare.
//
// channel   signals                                          direction
// config    arena_limit_we, arena_limit                      in
// command   start, busy, mode, request_size, free_address    in / busy out
// result    done, status, payload_address, granted_size      out
//
// The scan reads one entry a cycle through the registered table port; an insert
// or remove moves each entry through a read state and a write state. The longest
// allocate hits the first entry, then the split moves the rest up; a free that
// merges with both neighbors removes twice. A zero-size allocate answers
// ST_NOBLK without a scan. busy is high until done. Reset clears count and
// arena top and sets limit to ARENA_BYTES; the table needs no clearing.
// The result shows for one cycle with done; the receiver cannot stall it.
module first_fit_heap_allocator_top (
	input logic clk,
	input logic arst_n,
	input logic arena_limit_we,
	input logic [20:0] arena_limit,
	input logic start,
	output logic busy,
	input logic mode,
	input logic [20:0] request_size,
	input logic [19:0] free_address,
	output logic done,
	output logic [1:0] status,
	output logic [19:0] payload_address,
	output logic [20:0] granted_size
);
	localparam int IW = ffha_pkg::IDX_W;
	localparam int CW = ffha_pkg::CNT_W;
	localparam int XW = ffha_pkg::CALC_W;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SCAN = 4'd1;
	localparam logic [3:0] S_GROW = 4'd2;
	localparam logic [3:0] S_SPLIT = 4'd3;
	localparam logic [3:0] S_SHR = 4'd4;
	localparam logic [3:0] S_SHW = 4'd5;
	localparam logic [3:0] S_FIN = 4'd6;
	localparam logic [3:0] S_NXT = 4'd7;
	localparam logic [3:0] S_NXTW = 4'd8;
	localparam logic [3:0] S_PRV = 4'd9;
	localparam logic [3:0] S_PRVW = 4'd10;
	localparam logic [3:0] S_SHL = 4'd11;
	localparam logic [3:0] S_SHLW = 4'd12;
	localparam logic [3:0] S_RESP = 4'd13;

	logic [3:0] state_q;
	logic [CW-1:0] count_q;
	logic [XW-1:0] top_q;
	logic [20:0] limit_q;
	logic mode_q;
	logic [XW-1:0] size_q;
	logic [XW-1:0] addr_q;
	logic [CW-1:0] idx_q;     // scan/read pointer
	logic [CW-1:0] pos_q;     // target entry
	logic [CW-1:0] mv_q;      // shift pointer
	logic [CW-1:0] stop_q;    // shift stop
	logic rd_pend_q;
	ffha_pkg::entry_t cur_q;  // target entry image
	ffha_pkg::entry_t ins_q;  // entry inserted after shift
	logic after_rm_q;         // which merge step follows a remove
	logic [1:0] st_q;
	logic [19:0] pa_q;
	logic [20:0] gs_q;

	ffha_pkg::tbl_cmd_t cmd;
	ffha_pkg::entry_t rd;

	ffha_table u_table (.clk(clk), .cmd(cmd), .rdata(rd));

	// shared adder and comparator
	logic [XW-1:0] add_a, add_b, sum, cmp_a, cmp_b;
	logic ge;
	assign sum = add_a + add_b;
	assign ge = cmp_a >= cmp_b;

	logic [XW-1:0] rsize, alloc, lim;
	assign rsize = ({3'b0, request_size} + XW'(3)) & ~XW'(3);
	assign alloc = ((size_q + XW'(ffha_pkg::HEADER_BYTES + ffha_pkg::PAGE_BYTES - 1))
		>> ffha_pkg::PAGE_SH) << ffha_pkg::PAGE_SH;
	assign lim = (limit_q < 21'(ffha_pkg::ARENA_BYTES)) ? XW'(limit_q)
		: XW'(ffha_pkg::ARENA_BYTES);

	assign busy = state_q != S_IDLE;

	always_comb begin
		add_a = '0;
		add_b = '0;
		cmp_a = '0;
		cmp_b = '0;
		case (state_q)
			S_SCAN: begin
				add_a = XW'(rd.off);
				add_b = XW'(ffha_pkg::HEADER_BYTES);
				cmp_a = XW'(rd.bytes);
				cmp_b = size_q;
			end
			S_GROW: begin
				add_a = top_q;
				add_b = alloc;
				cmp_a = lim;
				cmp_b = sum;
			end
			S_SPLIT: begin
				add_a = size_q;
				add_b = XW'(ffha_pkg::HEADER_BYTES + ffha_pkg::MIN_SPLIT_BYTES);
				cmp_a = XW'(cur_q.bytes);
				cmp_b = sum;
			end
			S_NXTW, S_PRVW: begin
				add_a = XW'(rd.bytes) + XW'(ffha_pkg::HEADER_BYTES);
				add_b = XW'(cur_q.bytes);
			end
			default: ;
		endcase
	end

	logic [CW-1:0] raddr_n;
	logic we_n;
	logic [IW-1:0] wa_n;
	ffha_pkg::entry_t wd_n;
	logic [XW-1:0] soff;

	assign soff = XW'(cur_q.off) + XW'(ffha_pkg::HEADER_BYTES) + size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			top_q <= '0;
			limit_q <= 21'(ffha_pkg::ARENA_BYTES);
			done <= 1'b0;
			rd_pend_q <= 1'b0;
			mode_q <= ffha_pkg::MODE_ALLOC;
			size_q <= '0;
			addr_q <= '0;
			idx_q <= '0;
			pos_q <= '0;
			mv_q <= '0;
			stop_q <= '0;
			cur_q <= '0;
			ins_q <= '0;
			after_rm_q <= 1'b0;
			st_q <= ffha_pkg::ST_OK;
			pa_q <= '0;
			gs_q <= '0;
		end else begin
			done <= 1'b0;
			if (arena_limit_we) begin
				limit_q <= arena_limit;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						mode_q <= mode;
						size_q <= rsize;
						addr_q <= XW'(free_address);
						idx_q <= '0;
						rd_pend_q <= 1'b0;
						st_q <= ffha_pkg::ST_OK;
						pa_q <= '0;
						gs_q <= '0;
						if (mode == ffha_pkg::MODE_ALLOC && rsize == '0) begin
							st_q <= ffha_pkg::ST_NOBLK;
							state_q <= S_RESP;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					// rd holds entry idx_q-1 when rd_pend_q
					if (rd_pend_q && (mode_q == ffha_pkg::MODE_ALLOC
						? (rd.fr && ge) : (sum == addr_q))) begin
						pos_q <= idx_q - CW'(1);
						cur_q <= rd;
						rd_pend_q <= 1'b0;
						state_q <= mode_q == ffha_pkg::MODE_ALLOC ? S_SPLIT : S_NXT;
					end else if (idx_q == count_q) begin
						rd_pend_q <= 1'b0;
						if (mode_q != ffha_pkg::MODE_ALLOC) begin
							st_q <= ffha_pkg::ST_UNKNOWN;
							state_q <= S_RESP;
						end else if (count_q == CW'(ffha_pkg::MAX_BLOCKS)) begin
							st_q <= ffha_pkg::ST_NOBLK;
							state_q <= S_RESP;
						end else begin
							state_q <= S_GROW;
						end
					end else begin
						idx_q <= idx_q + CW'(1);
						rd_pend_q <= 1'b1;
					end
				end
				S_GROW: begin
					if (!ge) begin
						st_q <= ffha_pkg::ST_NOBLK;
						state_q <= S_RESP;
					end else begin
						pos_q <= count_q;
						cur_q.off <= top_q[19:0];
						cur_q.bytes <= 20'(alloc - XW'(ffha_pkg::HEADER_BYTES));
						cur_q.fr <= 1'b0;
						count_q <= count_q + CW'(1);
						top_q <= sum;
						state_q <= S_SPLIT;
					end
				end
				S_SPLIT: begin
					cur_q.fr <= 1'b0;
					if (count_q != CW'(ffha_pkg::MAX_BLOCKS) && ge) begin
						ins_q.off <= soff[19:0];
						ins_q.bytes <= 20'(XW'(cur_q.bytes) - size_q
							- XW'(ffha_pkg::HEADER_BYTES));
						ins_q.fr <= 1'b1;
						cur_q.bytes <= size_q[19:0];
						// move entries count-1 .. pos+1 up by one
						mv_q <= count_q;
						stop_q <= pos_q + CW'(1);
						count_q <= count_q + CW'(1);
						state_q <= S_SHR;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_SHR: begin
					if (mv_q == stop_q) begin
						// write the inserted entry
						state_q <= S_FIN;
					end else begin
						state_q <= S_SHW;
					end
				end
				S_SHW: begin
					state_q <= S_SHR;
					mv_q <= mv_q - CW'(1);
				end
				S_FIN: begin
					if (mode_q == ffha_pkg::MODE_ALLOC) begin
						pa_q <= 20'(XW'(cur_q.off) + XW'(ffha_pkg::HEADER_BYTES));
						gs_q <= 21'(cur_q.bytes);
					end
					state_q <= S_RESP;
				end
				S_NXT: begin
					cur_q.fr <= 1'b1;
					if (pos_q + CW'(1) < count_q) begin
						state_q <= S_NXTW;
					end else begin
						state_q <= S_PRV;
					end
				end
				S_NXTW: begin
					if (rd.fr) begin
						cur_q.bytes <= sum[19:0];
						mv_q <= pos_q + CW'(1);
						after_rm_q <= 1'b0;
						count_q <= count_q - CW'(1);
						state_q <= S_SHL;
					end else begin
						state_q <= S_PRV;
					end
				end
				S_PRV: begin
					if (pos_q != '0) begin
						state_q <= S_PRVW;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_PRVW: begin
					if (rd.fr) begin
						cur_q.off <= rd.off;
						cur_q.bytes <= sum[19:0];
						mv_q <= pos_q;
						pos_q <= pos_q - CW'(1);
						after_rm_q <= 1'b1;
						count_q <= count_q - CW'(1);
						state_q <= S_SHL;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_SHL: begin
					// entries mv+1 .. count move down; count already reduced
					if (mv_q >= count_q) begin
						state_q <= after_rm_q ? S_FIN : S_PRV;
					end else begin
						state_q <= S_SHLW;
					end
				end
				S_SHLW: begin
					mv_q <= mv_q + CW'(1);
					state_q <= S_SHL;
				end
				S_RESP: begin
					done <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// table port: read address picked in the cycle it is issued, write for
	// shift moves, the inserted entry and target write-back
	always_comb begin
		we_n = 1'b0;
		wa_n = '0;
		wd_n = cur_q;
		raddr_n = idx_q;
		case (state_q)
			S_SHR: begin
				raddr_n = mv_q - CW'(1);
				if (mv_q == stop_q) begin
					we_n = 1'b1;
					wa_n = stop_q[IW-1:0];
					wd_n = ins_q;
				end
			end
			S_SHW: begin
				// read of mv-1 was issued in S_SHR, data arrives now
				we_n = 1'b1;
				wa_n = mv_q[IW-1:0];
				wd_n = rd;
			end
			S_SHL: begin
				raddr_n = mv_q + CW'(1);
			end
			S_SHLW: begin
				we_n = 1'b1;
				wa_n = mv_q[IW-1:0];
				wd_n = rd;
			end
			S_NXT: begin
				raddr_n = pos_q + CW'(1);
			end
			S_PRV: begin
				raddr_n = pos_q - CW'(1);
			end
			S_FIN: begin
				we_n = 1'b1;
				wa_n = pos_q[IW-1:0];
			end
			default: ;
		endcase
	end

	always_comb begin
		cmd.we = we_n;
		cmd.waddr = wa_n;
		cmd.wdata = wd_n;
		cmd.raddr = raddr_n[IW-1:0];
	end

	assign status = st_q;
	assign payload_address = pa_q;
	assign granted_size = gs_q;
endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the first-fit heap allocator.
module tb;
	localparam logic MODE_FREE = ~ffha_pkg::MODE_ALLOC;
	localparam int STALL_LIMIT = 4000;

	typedef struct {
		logic [1:0] status;
		logic [19:0] payload_address;
		logic [20:0] granted_size;
	} heap_result_t;

	class heap_scoreboard;
		int unsigned blk_off[ffha_pkg::MAX_BLOCKS];
		int unsigned blk_bytes[ffha_pkg::MAX_BLOCKS];
		bit blk_free[ffha_pkg::MAX_BLOCKS];
		int blk_cnt;
		longint unsigned top;
		int unsigned limit;
		heap_result_t pending[$];
		int errors;

		function new();
			blk_cnt = 0;
			top = 0;
			limit = 1048576;
			errors = 0;
		endfunction

		function void tbl_insert(int pos, int unsigned o, int unsigned b, bit f);
			for (int k = blk_cnt; k > pos; k--) begin
				blk_off[k] = blk_off[k-1];
				blk_bytes[k] = blk_bytes[k-1];
				blk_free[k] = blk_free[k-1];
			end
			blk_off[pos] = o;
			blk_bytes[pos] = b;
			blk_free[pos] = f;
			blk_cnt++;
		endfunction

		function void tbl_remove(int pos);
			for (int k = pos; k + 1 < blk_cnt; k++) begin
				blk_off[k] = blk_off[k+1];
				blk_bytes[k] = blk_bytes[k+1];
				blk_free[k] = blk_free[k+1];
			end
			blk_cnt--;
		endfunction

		// payload offset of some live table entry, 0 if the table is empty
		function int unsigned pick_payload();
			if (blk_cnt == 0)
				return 0;
			return blk_off[$urandom_range(0, blk_cnt - 1)] + ffha_pkg::HEADER_BYTES;
		endfunction

		function void note_item(logic m, logic [20:0] req, logic [19:0] addr);
			heap_result_t r;
			longint unsigned sz, grow, cap;
			int i;
			r.status = ffha_pkg::ST_OK;
			r.payload_address = '0;
			r.granted_size = '0;
			if (m == ffha_pkg::MODE_ALLOC) begin
				sz = (longint'(req) + 3) & ~longint'(3);
				if (sz == 0) begin
					r.status = ffha_pkg::ST_NOBLK;
					pending.push_back(r);
					return;
				end
				for (i = 0; i < blk_cnt; i++)
					if (blk_free[i] && blk_bytes[i] >= sz) break;
				if (i == blk_cnt) begin
					grow = ((sz + ffha_pkg::HEADER_BYTES + ffha_pkg::PAGE_BYTES - 1)
						/ ffha_pkg::PAGE_BYTES) * ffha_pkg::PAGE_BYTES;
					cap = (limit < ffha_pkg::ARENA_BYTES) ? limit : ffha_pkg::ARENA_BYTES;
					if (blk_cnt >= ffha_pkg::MAX_BLOCKS || top + grow > cap) begin
						r.status = ffha_pkg::ST_NOBLK;
						pending.push_back(r);
						return;
					end
					tbl_insert(blk_cnt, top, grow - ffha_pkg::HEADER_BYTES, 0);
					top += grow;
					i = blk_cnt - 1;
				end
				blk_free[i] = 0;
				if (blk_cnt < ffha_pkg::MAX_BLOCKS && blk_bytes[i] >=
					sz + ffha_pkg::HEADER_BYTES + ffha_pkg::MIN_SPLIT_BYTES)
				begin
					tbl_insert(i + 1, blk_off[i] + ffha_pkg::HEADER_BYTES + sz,
						blk_bytes[i] - sz - ffha_pkg::HEADER_BYTES, 1);
					blk_bytes[i] = sz;
				end
				r.payload_address = blk_off[i] + ffha_pkg::HEADER_BYTES;
				r.granted_size = blk_bytes[i];
			end else begin
				for (i = 0; i < blk_cnt; i++)
					if (blk_off[i] + ffha_pkg::HEADER_BYTES == addr) break;
				if (i == blk_cnt) begin
					r.status = ffha_pkg::ST_UNKNOWN;
				end else begin
					blk_free[i] = 1;
					if (i + 1 < blk_cnt && blk_free[i+1]) begin
						blk_bytes[i] += ffha_pkg::HEADER_BYTES + blk_bytes[i+1];
						tbl_remove(i + 1);
					end
					if (i > 0 && blk_free[i-1]) begin
						blk_bytes[i-1] += ffha_pkg::HEADER_BYTES + blk_bytes[i];
						tbl_remove(i);
					end
				end
			end
			pending.push_back(r);
		endfunction

		function void check(logic [1:0] st, logic [19:0] pa, logic [20:0] gs);
			heap_result_t e;
			if (pending.size() == 0) begin
				$error("result with nothing expected: status %0d", st);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (st !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, st);
				errors++;
			end
			if (pa !== e.payload_address) begin
				$error("payload_address: expected %0h, got %0h", e.payload_address, pa);
				errors++;
			end
			if (gs !== e.granted_size) begin
				$error("granted_size: expected %0d, got %0d", e.granted_size, gs);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic arena_limit_we;
	logic [20:0] arena_limit;
	logic start, mode;
	logic [20:0] request_size;
	logic [19:0] free_address;
	logic busy, done;
	logic [1:0] status;
	logic [19:0] payload_address;
	logic [20:0] granted_size;

	heap_scoreboard sb = new();
	int quiet_cycles;
	int idle_pct;

	first_fit_heap_allocator_top uut (
		.clk(clk), .arst_n(arst_n),
		.arena_limit_we(arena_limit_we), .arena_limit(arena_limit),
		.start(start), .busy(busy), .mode(mode),
		.request_size(request_size), .free_address(free_address),
		.done(done), .status(status),
		.payload_address(payload_address), .granted_size(granted_size)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check(status, payload_address, granted_size);
	end

	// watchdog: cycles with no item taken and no result seen
	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy) || arena_limit_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	task automatic send_item(logic m, logic [20:0] req, logic [19:0] addr);
		start <= 1'b1;
		mode <= m;
		request_size <= req;
		free_address <= addr;
		do @(posedge clk); while (busy);
		sb.note_item(m, req, addr);
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0 || busy) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(logic [20:0] v);
		drain();
		arena_limit_we <= 1'b1;
		arena_limit <= v;
		@(posedge clk);
		arena_limit_we <= 1'b0;
		sb.limit = v;
		@(posedge clk);
	endtask

	task automatic random_item();
		int unsigned r, a;
		r = $urandom_range(0, 99);
		if (r < 52) begin
			r = $urandom_range(0, 99);
			if (r < 70)
				send_item(ffha_pkg::MODE_ALLOC, 21'($urandom_range(1, 600)), 20'($urandom));
			else if (r < 92)
				send_item(ffha_pkg::MODE_ALLOC, 21'($urandom_range(1, 9000)), 20'($urandom));
			else if (r < 96)
				send_item(ffha_pkg::MODE_ALLOC, 21'($urandom_range(0, 4)), 20'($urandom));
			else
				send_item(ffha_pkg::MODE_ALLOC, 21'($urandom_range(0, 1048576)),
					20'($urandom));
		end else begin
			r = $urandom_range(0, 99);
			a = sb.pick_payload();
			if (r < 85) send_item(MODE_FREE, 21'($urandom), 20'(a));
			else if (r < 92) send_item(MODE_FREE, 21'($urandom), 20'(a + 4));
			else send_item(MODE_FREE, 21'($urandom), 20'($urandom_range(0, 20'hFFFFF)));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		arena_limit_we = 1'b0;
		arena_limit = 21'd1048576;
		start = 1'b0;
		mode = ffha_pkg::MODE_ALLOC;
		request_size = '0;
		free_address = '0;
		quiet_cycles = 0;
		idle_pct = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, rounding, unknown frees, double free, growth limit
		send_item(MODE_FREE, '0, '0);
		send_item(ffha_pkg::MODE_ALLOC, 21'd0, 20'hFFFFF);
		send_item(ffha_pkg::MODE_ALLOC, 21'd1, '0);
		send_item(ffha_pkg::MODE_ALLOC, 21'd3, '0);
		send_item(ffha_pkg::MODE_ALLOC, 21'd4064, '0);
		send_item(ffha_pkg::MODE_ALLOC, 21'd4065, '0);
		send_item(MODE_FREE, 21'h1FFFFF, 20'd32);
		send_item(MODE_FREE, '0, 20'd32);
		send_item(ffha_pkg::MODE_ALLOC, 21'd100, '0);
		send_item(MODE_FREE, '0, 20'hFFFFF);
		send_item(ffha_pkg::MODE_ALLOC, 21'd1048576, '0);
		send_item(ffha_pkg::MODE_ALLOC, 21'd1048573, '0);
		send_item(MODE_FREE, '0, 20'(sb.pick_payload()));
		send_item(MODE_FREE, '0, 20'(sb.pick_payload()));
		write_limit(21'd4096);
		send_item(ffha_pkg::MODE_ALLOC, 21'd4064, '0);
		send_item(ffha_pkg::MODE_ALLOC, 21'd4000, '0);
		send_item(ffha_pkg::MODE_ALLOC, 21'd8, '0);
		write_limit(21'd1048576);
		// fill the table with small blocks, then exercise the full cases
		repeat (70) send_item(ffha_pkg::MODE_ALLOC, 21'd8, '0);
		send_item(ffha_pkg::MODE_ALLOC, 21'd100000, '0);
		send_item(MODE_FREE, '0, 20'(sb.pick_payload()));
		send_item(ffha_pkg::MODE_ALLOC, 21'd4, '0);
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 19 : (ph == 1) ? 75 : 0;
			write_limit(ph == 0 ? 21'd65536 : ph == 1 ? 21'd4096 : 21'd1048576);
			repeat (230) random_item();
			drain();
			write_limit(ph == 1 ? 21'd1048576 : 21'd20480);
			repeat (230) random_item();
		end
		drain();
		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end
endmodule
